// ----- rtl/scala_note_to_pitch_assert.svh -----
// Assertion macros shared by the RTL files.
`ifndef SCALA_NOTE_TO_PITCH_ASSERT_SVH
`define SCALA_NOTE_TO_PITCH_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define SNP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/snp_pkg.sv -----
// ---------------------------------------------------------------------------
// snp_pkg
// Shared types and constants for the note-to-pitch converter.
// ---------------------------------------------------------------------------
`default_nettype none
package snp_pkg;
  localparam int MAP_DEPTH       = 128;
  localparam int SCALE_DEPTH     = 128;
  localparam int RATIO_FRAC_BITS = 24;
  localparam int MAP_AW          = 7;
  localparam int SCALE_AW        = 7;

  localparam logic [1:0] REQ_CONVERT   = 2'd0;
  localparam logic [1:0] REQ_MAP_WR    = 2'd1;
  localparam logic [1:0] REQ_SCALE_WR  = 2'd2;

  localparam logic [2:0] CFG_MAP_SIZE   = 3'd0;
  localparam logic [2:0] CFG_SCALE_SIZE = 3'd1;
  localparam logic [2:0] CFG_ZERO_NOTE  = 3'd2;
  localparam logic [2:0] CFG_REPEAT_INC = 3'd3;
  localparam logic [2:0] CFG_BASE_PITCH = 3'd4;
  localparam logic [2:0] CFG_INV_PERIOD = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV1, ST_MAPRD, ST_MAPWT, ST_DEG, ST_DIV2,
    ST_PRD, ST_PWT, ST_OCT, ST_SRD, ST_SWT, ST_SCL, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // latch request, start first divide
    logic div_step;
    logic map_rd;
    logic deg_load;  // form degree, start second divide
    logic per_rd;    // read period ratio
    logic factor_ld; // latch octave factor
    logic oct_step;
    logic scl_rd;
    logic scl_mul;
    logic done;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic is_convert;
    logic unmapped;
    logic oct_left;
    logic sidx_nz;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/snp_ram.sv -----
// ---------------------------------------------------------------------------
// snp_ram
// Generic single-port-write, single-read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module snp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/snp_ctrl.sv -----
// ---------------------------------------------------------------------------
// snp_ctrl
// Sequencer for one request: divides, table reads, octave loop, scaling.
// ---------------------------------------------------------------------------
`default_nettype none
`include "scala_note_to_pitch_assert.svh"
module snp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output snp_pkg::ctl_t      ctl,
  input  wire snp_pkg::sts_t sts
);
  import snp_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (!sts.is_convert) begin
          state_next = ST_DONE;
        end else if (sts.div_busy) begin
          ctl.div_step = 1'b1;
        end else begin
          ctl.map_rd = 1'b1;
          state_next = ST_MAPRD;
        end
      end
      ST_MAPRD: state_next = ST_MAPWT;
      ST_MAPWT: begin
        if (sts.unmapped) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DEG;
        end
      end
      ST_DEG: begin
        ctl.deg_load = 1'b1;
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        if (sts.div_busy) begin
          ctl.div_step = 1'b1;
        end else begin
          ctl.per_rd = 1'b1;
          state_next = ST_PRD;
        end
      end
      ST_PRD: state_next = ST_PWT;
      ST_PWT: begin
        ctl.factor_ld = 1'b1;
        state_next = ST_OCT;
      end
      ST_OCT: begin
        if (sts.oct_left) begin
          ctl.oct_step = 1'b1;
        end else begin
          ctl.scl_rd = 1'b1;
          state_next = ST_SRD;
        end
      end
      ST_SRD: state_next = ST_SWT;
      ST_SWT: begin
        state_next = ST_SCL;
      end
      ST_SCL: begin
        if (sts.sidx_nz) begin
          ctl.scl_mul = 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        ctl.done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SNP_ASSERT_NEXT(a_load_leaves_idle, ctl.load, state == ST_DIV1)
  `SNP_ASSERT_IMPL(a_done_one_state, ctl.done, state == ST_DONE)
  `SNP_ASSERT_IMPL(a_busy_no_load, busy, !ctl.load)
endmodule
`default_nettype wire

// ----- rtl/snp_dp.sv -----
// ---------------------------------------------------------------------------
// snp_dp
// Datapath: request registers, bit-serial floor divider, tables, multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
`include "scala_note_to_pitch_assert.svh"
module snp_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire snp_pkg::ctl_t ctl,
  output snp_pkg::sts_t      sts,
  input  wire logic [1:0]    req_type,
  input  wire logic [6:0]    note,
  input  wire logic [6:0]    table_index,
  input  wire logic signed [10:0] map_degree,
  input  wire logic [31:0]   ratio_value,
  input  wire logic [7:0]    map_size,
  input  wire logic [7:0]    scale_size,
  input  wire logic [6:0]    zero_note,
  input  wire logic [9:0]    map_repeat_inc,
  input  wire logic [31:0]   base_pitch,
  input  wire logic [31:0]   inverse_period,
  output logic               result_valid,
  output logic [31:0]        pitch,
  output logic               unmapped,
  output logic               saturated
);
  import snp_pkg::*;

  localparam int DW = 19; // |degree| < 2^18
  localparam logic [63:0] ROUND = 64'(1) << (RATIO_FRAC_BITS - 1);

  logic [1:0]  req;
  logic [7:0]  msz, ssz;
  logic [7:0]  dvs;
  logic        neg;
  logic [DW-1:0] dvd;      // magnitude dividend, shifting
  logic [7:0]  rem;
  logic [4:0]  cnt;
  logic        dbusy;
  logic signed [DW-1:0] quo;
  logic [7:0]  rmod;
  logic signed [DW-1:0] reps;
  logic [10:0] entry;
  logic        unm;
  logic [31:0] acc, factor;
  logic [DW-1:0] nleft;
  logic        sat;
  logic [SCALE_AW-1:0] sidx;
  logic        map_we, scl_we, map0_ok;
  logic [10:0] map_q;
  logic [31:0] scl_q;
  logic [SCALE_AW-1:0] scl_ra;
  logic [63:0] prod;
  logic [64:0] rnd;
  logic [31:0] mres;
  logic        mover;
  logic [31:0] mul_b;
  logic [8:0]  rtrial;
  logic signed [DW-1:0] qfin;
  logic [7:0]  rfin;
  logic signed [DW+11:0] degw;
  logic        map_rd_q, map_wt;
  logic        scl_sel;   // scale read address moved from period to sidx
  logic        neg_oct;
  logic        unm_now;

  assign msz = (map_size == 8'd0) ? 8'd1 :
               ((map_size > 8'(MAP_DEPTH)) ? 8'(MAP_DEPTH) : map_size);
  assign ssz = (scale_size == 8'd0) ? 8'd1 :
               ((scale_size > 8'(SCALE_DEPTH)) ? 8'(SCALE_DEPTH) : scale_size);

  assign map_we = ctl.load && (req_type == REQ_MAP_WR);
  assign scl_we = ctl.load && (req_type == REQ_SCALE_WR);

  snp_ram #(.WIDTH(11), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(table_index), .wdata(map_degree),
    .raddr(rmod[MAP_AW-1:0]), .rdata(map_q));

  assign scl_ra = (scl_sel || ctl.scl_rd) ? SCALE_AW'(sidx - 7'd1) :
                                            SCALE_AW'(ssz - 8'd1);
  snp_ram #(.WIDTH(32), .DEPTH(SCALE_DEPTH)) u_scl (
    .clk(clk), .we(scl_we), .waddr(table_index), .wdata(ratio_value),
    .raddr(scl_ra), .rdata(scl_q));

  // restoring divider on magnitude, floor correction at the end
  assign rtrial = {rem, dvd[DW-1]};
  always_comb begin
    if (!neg) begin
      qfin = $signed(quo);
      rfin = rem;
    end else if (rem == 8'd0) begin
      qfin = -$signed(quo);
      rfin = 8'd0;
    end else begin
      qfin = -$signed(quo) - DW'(1);
      rfin = dvs - rem;
    end
  end

  assign degw = $signed(reps) * $signed({1'b0, map_repeat_inc}) + $signed({1'b0, entry});

  assign mul_b = ctl.scl_mul ? scl_q : factor;
  assign prod = acc * mul_b;
  assign rnd = {1'b0, prod} + {1'b0, ROUND};
  assign mover = |rnd[64:32+RATIO_FRAC_BITS];
  assign mres = mover ? 32'hFFFF_FFFF : rnd[31+RATIO_FRAC_BITS:RATIO_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      result_valid <= 1'b0;
      map0_ok <= 1'b1;
      map_rd_q <= 1'b0;
      map_wt <= 1'b0;
      scl_sel <= 1'b0;
    end else begin
      result_valid <= ctl.done;
      map_rd_q <= ctl.map_rd;
      map_wt <= map_rd_q;
      if (map_we && table_index == 7'd0) begin
        map0_ok <= 1'b0;
      end
      if (ctl.load) begin
        scl_sel <= 1'b0;
      end else if (ctl.scl_rd) begin
        scl_sel <= 1'b1;
      end
      if (ctl.load || ctl.deg_load) begin
        dbusy <= 1'b1;
      end else if (ctl.div_step && cnt == 5'd0) begin
        dbusy <= 1'b0;
      end
    end
    if (ctl.load) begin
      req <= req_type;
      unm <= 1'b0;
      sat <= 1'b0;
      acc <= base_pitch;
      dvs <= msz;
      neg <= (note < zero_note);
      dvd <= (note < zero_note) ? DW'(zero_note - note) : DW'(note - zero_note);
      rem <= '0;
      quo <= '0;
      cnt <= 5'(DW - 1);
    end
    if (map_wt && unm_now) begin
      unm <= 1'b1;
    end
    if (ctl.div_step) begin
      dvd <= dvd << 1;
      cnt <= cnt - 5'd1;
      if (rtrial >= {1'b0, dvs}) begin
        rem <= 8'(rtrial - {1'b0, dvs});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rtrial[7:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
    if (ctl.map_rd) begin
      reps <= qfin;
      rmod <= rfin;
    end
    if (ctl.deg_load) begin
      dvs <= ssz;
      neg <= degw[DW+11];
      dvd <= degw[DW+11] ? DW'(-degw) : DW'(degw);
      rem <= '0;
      quo <= '0;
      cnt <= 5'(DW - 1);
    end
    if (ctl.per_rd) begin
      nleft <= qfin[DW-1] ? DW'(-qfin) : DW'(qfin);
      sidx <= SCALE_AW'(rfin);
      factor <= qfin[DW-1] ? inverse_period : 32'd0;
      neg_oct <= qfin[DW-1];
    end
    if (ctl.factor_ld && !neg_oct) begin
      factor <= scl_q;
    end
    if (ctl.oct_step) begin
      if (mover) sat <= 1'b1;
      if (mres == acc) begin
        nleft <= '0;
      end else begin
        acc <= mres;
        nleft <= nleft - DW'(1);
      end
    end
    if (ctl.scl_mul) begin
      acc <= mres;
      if (mover) sat <= 1'b1;
    end
    if (ctl.done) begin
      pitch <= (req != REQ_CONVERT || unm) ? 32'd0 : acc;
      unmapped <= (req == REQ_CONVERT) && unm;
      saturated <= (req == REQ_CONVERT) && !unm && sat;
    end
  end

  // entry zero reads as 0 until written
  always_comb begin
    entry = (map0_ok && rmod == 8'd0) ? 11'd0 : map_q;
  end

  assign unm_now = entry[10];

  always_comb begin
    sts.div_busy   = dbusy;
    sts.is_convert = (req == REQ_CONVERT);
    sts.unmapped   = unm_now;
    sts.oct_left   = (nleft != '0);
    sts.sidx_nz    = (sidx != '0);
  end

  `SNP_ASSERT_NEXT(a_done_valid, ctl.done, result_valid)
  `SNP_ASSERT_IMPL(a_sat_clamped, result_valid && saturated, unmapped == 1'b0)
  `SNP_ASSERT_IMPL(a_unm_zero, result_valid && unmapped, pitch == 32'd0)
endmodule
`default_nettype wire

// ----- rtl/scala_note_to_pitch.sv -----
// ---------------------------------------------------------------------------
// scala_note_to_pitch
// Keyboard-mapped note to fixed-point frequency converter.
//
// A request is taken when start is high and busy is low. It converts a note
// or writes one key-map or scale-table entry. Each request gives exactly one
// result: result_valid is high for one cycle with pitch, unmapped and
// saturated; the receiver cannot stall. A write or unknown request skips the
// divides and table reads and goes straight to the done state. A conversion
// runs two 19-step bit-serial floor divides, three table reads (key map,
// period ratio, scale entry), one multiply per octave step and a final scale
// multiply when the scale index is nonzero. The octave steps taken are at
// most |octaves|, fewer once the pitch stops changing; an unmapped note ends
// after the key-map read. busy drops in the result cycle, so the next request
// can be taken there, never while one is in progress. Configuration writes
// use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and
// writes belong only in idle periods. Reset restores register defaults;
// key-map entry zero reads as 0 until written. No clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
module scala_note_to_pitch (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [6:0]  note,
  input  wire logic [6:0]  table_index,
  input  wire logic signed [10:0] map_degree,
  input  wire logic [31:0] ratio_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             result_valid,
  output logic [31:0]      pitch,
  output logic             unmapped,
  output logic             saturated
);
  import snp_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic busy_c;
  logic [7:0]  map_size, scale_size;
  logic [6:0]  zero_note;
  logic [9:0]  map_repeat_inc;
  logic [31:0] base_pitch, inverse_period;

  assign cfg_ready = 1'b1;
  assign busy = busy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= 8'd1;
      scale_size <= 8'd12;
      zero_note <= 7'd0;
      map_repeat_inc <= 10'd1;
      base_pitch <= 32'd535809;
      inverse_period <= 32'd8388608;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAP_SIZE:   map_size <= cfg_data[7:0];
        CFG_SCALE_SIZE: scale_size <= cfg_data[7:0];
        CFG_ZERO_NOTE:  zero_note <= cfg_data[6:0];
        CFG_REPEAT_INC: map_repeat_inc <= cfg_data[9:0];
        CFG_BASE_PITCH: base_pitch <= cfg_data;
        CFG_INV_PERIOD: inverse_period <= cfg_data;
        default: ;
      endcase
    end
  end

  snp_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy_c), .ctl(ctl), .sts(sts));

  snp_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .req_type(req_type), .note(note), .table_index(table_index),
    .map_degree(map_degree), .ratio_value(ratio_value),
    .map_size(map_size), .scale_size(scale_size), .zero_note(zero_note),
    .map_repeat_inc(map_repeat_inc), .base_pitch(base_pitch),
    .inverse_period(inverse_period),
    .result_valid(result_valid), .pitch(pitch), .unmapped(unmapped),
    .saturated(saturated));
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking regression for the note-to-pitch converter.
//
// An initial block loads the tables, sets the registers and fills a queue of
// pending requests; a falling-edge driver presents them with random gaps and
// a rising-edge monitor predicts each accepted transaction and compares every
// result against the oldest prediction. Register settings change between
// phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
  import snp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [6:0]  note;
    logic [6:0]  tidx;
    logic [10:0] mdeg;
    logic [31:0] ratio;
  } req_t;

  typedef struct packed {
    logic [31:0] pitch;
    logic        unmapped;
    logic        saturated;
  } pitch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = REQ_CONVERT;
  logic [6:0] note = '0;
  logic [6:0] table_index = '0;
  logic signed [10:0] map_degree = '0;
  logic [31:0] ratio_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic result_valid;
  logic [31:0] pitch;
  logic unmapped;
  logic saturated;

  scala_note_to_pitch dut (.*);

  always #5 clk = ~clk;

  // model copy of registers and tables
  logic [7:0]  m_map_size, m_scale_size;
  logic [6:0]  m_zero_note;
  logic [9:0]  m_repeat_inc;
  logic [31:0] m_base_pitch, m_inv_period;
  logic [10:0] m_key_map [MAP_DEPTH];
  logic [31:0] m_scale [SCALE_DEPTH];

  req_t   pending_reqs[$];
  pitch_t expected_pitches[$];
  req_t   cur_req;
  logic   took = 1'b0;
  int     idle_pct = 0;
  int     errors = 0;

  function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] r, ref logic sat);
    longint unsigned p;
    p = (longint'(a) * longint'(r) + (64'd1 << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS;
    if (p > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return p[31:0];
  endfunction

  function automatic void floor_div(int x, int m, output int q, output int r);
    q = x / m;
    r = x % m;
    if (r < 0) begin
      r += m;
      q -= 1;
    end
  endfunction

  function automatic pitch_t predict_pitch(req_t r);
    pitch_t res;
    int msz, ssz, reps, midx, entry, degree, octs, sidx, n;
    logic [31:0] acc, factor, nxt;
    logic sat;
    res = '0;
    sat = 1'b0;
    if (r.req == REQ_MAP_WR) begin
      m_key_map[r.tidx] = r.mdeg;
      return res;
    end
    if (r.req == REQ_SCALE_WR) begin
      m_scale[r.tidx] = r.ratio;
      return res;
    end
    if (r.req != REQ_CONVERT) return res;
    msz = (m_map_size == 0) ? 1 : (m_map_size > MAP_DEPTH ? MAP_DEPTH : m_map_size);
    ssz = (m_scale_size == 0) ? 1 : (m_scale_size > SCALE_DEPTH ? SCALE_DEPTH : m_scale_size);
    floor_div(int'(r.note) - int'(m_zero_note), msz, reps, midx);
    entry = int'($signed(m_key_map[midx]));
    if (entry < 0) begin
      res.unmapped = 1'b1;
      return res;
    end
    degree = reps * int'(m_repeat_inc) + entry;
    floor_div(degree, ssz, octs, sidx);
    acc = m_base_pitch;
    if (octs >= 0) begin
      factor = m_scale[ssz - 1];
      n = octs;
    end else begin
      factor = m_inv_period;
      n = -octs;
    end
    while (n > 0) begin
      nxt = fx_mul(acc, factor, sat);
      if (nxt == acc) break;
      acc = nxt;
      n--;
    end
    if (sidx != 0) acc = fx_mul(acc, m_scale[sidx - 1], sat);
    res.pitch = acc;
    res.saturated = sat;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur_req = pending_reqs.pop_front();
        start <= 1'b1;
        req_type <= cur_req.req;
        note <= cur_req.note;
        table_index <= cur_req.tidx;
        map_degree <= cur_req.mdeg;
        ratio_value <= cur_req.ratio;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pitch_t exp_r;
    took = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        took = 1'b1;
        expected_pitches.insert(expected_pitches.size(), predict_pitch(cur_req));
      end
      if (result_valid) begin
        if (expected_pitches.size() == 0) begin
          $error("result with no transaction pending: pitch %h", pitch);
          errors++;
        end else begin
          exp_r = expected_pitches.pop_front();
          if (pitch !== exp_r.pitch) begin
            $error("pitch expected %h actual %h", exp_r.pitch, pitch);
            errors++;
          end
          if (unmapped !== exp_r.unmapped) begin
            $error("unmapped expected %b actual %b", exp_r.unmapped, unmapped);
            errors++;
          end
          if (saturated !== exp_r.saturated) begin
            $error("saturated expected %b actual %b", exp_r.saturated, saturated);
            errors++;
          end
        end
      end
    end
  end

  task automatic enqueue(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAP_SIZE:   m_map_size = data[7:0];
      CFG_SCALE_SIZE: m_scale_size = data[7:0];
      CFG_ZERO_NOTE:  m_zero_note = data[6:0];
      CFG_REPEAT_INC: m_repeat_inc = data[9:0];
      CFG_BASE_PITCH: m_base_pitch = data;
      CFG_INV_PERIOD: m_inv_period = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int msz, int ssz, int zn, int inc, logic [31:0] bp,
                           logic [31:0] ip);
    cfg_write(CFG_MAP_SIZE, msz);
    cfg_write(CFG_SCALE_SIZE, ssz);
    cfg_write(CFG_ZERO_NOTE, zn);
    cfg_write(CFG_REPEAT_INC, inc);
    cfg_write(CFG_BASE_PITCH, bp);
    cfg_write(CFG_INV_PERIOD, ip);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_pitches.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic req_t mk(logic [1:0] rq, int nt, int ti, int md, logic [31:0] rv);
    req_t r;
    r.req = rq;
    r.note = 7'(nt);
    r.tidx = 7'(ti);
    r.mdeg = 11'(md);
    r.ratio = rv;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    r.note = 7'($urandom);
    r.tidx = 7'($urandom);
    r.mdeg = 11'($urandom);
    r.ratio = $urandom;
    k = $urandom_range(99);
    if (k < 62) r.req = REQ_CONVERT;
    else if (k < 78) r.req = REQ_MAP_WR;
    else if (k < 94) r.req = REQ_SCALE_WR;
    else r.req = REQ_UNUSED;
    k = $urandom_range(9);
    if (k < 6) r.mdeg = 11'($urandom_range(40));
    else if (k == 6) r.mdeg = '1;
    else if (k == 7) r.mdeg = 11'd1023;
    k = $urandom_range(9);
    if (k < 8) r.ratio = 32'h0100_0000 + $urandom_range(32'h0100_0000);
    return r;
  endfunction

  task automatic run_phase(int n, int idle);
    idle_pct = idle;
    repeat (n) enqueue(rand_req());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    configure(1, 12, 0, 1, 535809, 8388608);
    for (int i = 0; i < MAP_DEPTH; i++) begin
      enqueue(mk(REQ_MAP_WR, 0, i, $urandom_range(24), 0));
      enqueue(mk(REQ_SCALE_WR, 0, i, 0, 32'h0100_0000 + $urandom_range(32'h00FF_FFFF)));
    end
    drain();

    // directed corners under default settings
    enqueue(mk(REQ_CONVERT, 0, 0, 0, 0));
    enqueue(mk(REQ_CONVERT, 127, 0, 0, 0));
    enqueue(mk(REQ_MAP_WR, 0, 0, -1, 0));
    enqueue(mk(REQ_CONVERT, 69, 0, 0, 0));
    enqueue(mk(REQ_MAP_WR, 0, 0, -1024, 0));
    enqueue(mk(REQ_CONVERT, 5, 0, 0, 0));
    enqueue(mk(REQ_MAP_WR, 0, 0, 1023, 32'hFFFF_FFFF));
    enqueue(mk(REQ_CONVERT, 127, 0, 0, 0));
    enqueue(mk(REQ_MAP_WR, 127, 127, 0, 0));
    enqueue(mk(REQ_SCALE_WR, 0, 11, 0, 32'hFFFF_FFFF));
    enqueue(mk(REQ_CONVERT, 24, 0, 0, 0));
    enqueue(mk(REQ_SCALE_WR, 0, 11, 0, 0));
    enqueue(mk(REQ_CONVERT, 30, 0, 0, 0));
    enqueue(mk(REQ_SCALE_WR, 127, 11, 0, 32'h0200_0000));
    enqueue(mk(REQ_UNUSED, 127, 127, -1, 32'hFFFF_FFFF));
    enqueue(mk(REQ_MAP_WR, 0, 0, 0, 0));
    enqueue(mk(REQ_CONVERT, 60, 0, 0, 0));
    drain();
    configure(12, 12, 69, 12, 32'd28835840, 8388608);  // 440 Hz at note 69
    enqueue(mk(REQ_CONVERT, 0, 0, 0, 0));
    enqueue(mk(REQ_CONVERT, 69, 0, 0, 0));
    enqueue(mk(REQ_CONVERT, 127, 0, 0, 0));
    drain();

    run_phase(180, 0);
    configure(128, 128, 127, 0, $urandom, $urandom);
    run_phase(160, 74);
    configure(0, 0, 0, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(8, 0);
    configure(255, 255, 60, 3, 32'd1, 32'h0080_0000);
    run_phase(160, 7);
    configure($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(127),
              $urandom_range(1, 24), $urandom, $urandom_range(32'h0100_0000));
    run_phase(170, 0);
    configure(7, 5, 64, 2, 32'd535809, 32'h00AA_AAAB);
    run_phase(170, 74);
    configure(12, 12, 69, 12, 32'd28835840, 8388608);
    run_phase(176, 0);

    repeat (60) @(posedge clk);
    if (errors == 0 && expected_pitches.size() == 0) begin
      $display("scala_note_to_pitch regression: pass");
    end else begin
      $display("scala_note_to_pitch regression: fail");
    end
    $finish;
  end

  initial begin
    #10s;
    $display("scala_note_to_pitch regression: fail");
    $finish;
  end
endmodule
